FILE: rtl/core/masked_route_table_assert.svh
// Assertion macros for the masked route table checker.
// Needs nothing else; included by files that hold concurrent assertions.
`ifndef MASKED_ROUTE_TABLE_ASSERT_SVH
`define MASKED_ROUTE_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MRT_ASSERT_IMPLIES(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MRT_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/mrt_pkg.sv
// Shared types, constants and helpers of the masked route table.
// Used by the interfaces and by every module of the block.
package mrt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = CNT_W + 1;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_DELETE = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_MISS = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SHIFT
    } t_state;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] dest_addr;
        logic [31:0] net_mask;
        logic [31:0] gateway_addr;
        logic [7:0]  port_id;
        logic [15:0] route_cost;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [7:0]  hit_index;
        logic [31:0] hit_gateway;
        logic [31:0] hit_mask;
        logic [7:0]  hit_port;
        logic [15:0] hit_cost;
    } t_rsp;

    typedef struct packed {
        logic [31:0] dest;
        logic [31:0] mask;
        logic [31:0] gateway;
        logic [7:0]  port;
        logic [15:0] cost;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        t_entry           data;
    } t_mem_wr;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] dest;
        logic [31:0] mask;
        logic        exact;
    } t_cmp_req;

    // Network byte order to host order.
    function automatic logic [31:0] swap_bytes(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

FILE: rtl/core/mrt_req_if.sv
// Request channel of the masked route table: valid, ready and one request item.
// Depends on mrt_pkg.
interface mrt_req_if;
    logic          valid;
    logic          ready;
    mrt_pkg::t_req payload;

    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
    modport mon(input valid, input ready, input payload);
endinterface

FILE: rtl/core/mrt_rsp_if.sv
// Result channel of the masked route table: valid, ready and one result item.
// Depends on mrt_pkg.
interface mrt_rsp_if;
    logic          valid;
    logic          ready;
    mrt_pkg::t_rsp payload;

    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
    modport mon(input valid, input ready, input payload);
endinterface

FILE: rtl/core/masked_route_table.sv
// Masked route table top level: sequencer, shared compare unit and route storage.
// Depends on mrt_pkg, mrt_req_if, mrt_rsp_if, mrt_ctrl, mrt_match and mrt_mem.
//
//   Channel   Modport  Item
//   i_req     sink     operation, dest_addr, net_mask, gateway_addr, port_id, route_cost
//   o_rsp     source   status, hit_index, hit_gateway, hit_mask, hit_port, hit_cost
//
// An add, or any request that resolves without a scan, is answered straight from idle.
// A lookup inspects the entries in order up to the first match.
// A delete scans like a lookup, then moves each later entry up one place.
// The single compare unit and the one-read, one-write route storage make the scan serial.
// Reset clears the entry count and the sequencer; no clearing pass is needed.
// A request is taken only while idle and the result register is empty or being read.
module masked_route_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mrt_req_if.sink     i_req,
    mrt_rsp_if.source   o_rsp
);
    mrt_pkg::t_mem_wr               mem_wr;
    logic [mrt_pkg::IDX_W-1:0]      mem_raddr;
    mrt_pkg::t_entry                mem_rdata;
    mrt_pkg::t_cmp_req              cmp_req;
    logic                           cmp_match;

    mrt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .o_wr    (mem_wr),
        .o_raddr (mem_raddr),
        .i_rdata (mem_rdata),
        .o_cmp   (cmp_req),
        .i_match (cmp_match)
    );

    mrt_match u_match (
        .i_cmp   (cmp_req),
        .o_match (cmp_match)
    );

    mrt_mem u_mem (
        .i_clk   (i_clk),
        .i_wr    (mem_wr),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );
endmodule

FILE: rtl/core/mrt_mem.sv
// Route storage: one write port and one read port with registered read data.
// Depends on mrt_pkg.
module mrt_mem (
    input  logic                        i_clk,
    input  mrt_pkg::t_mem_wr            i_wr,
    input  logic [mrt_pkg::IDX_W-1:0]   i_raddr,
    output mrt_pkg::t_entry             o_rdata
);
    mrt_pkg::t_entry r_mem [mrt_pkg::TABLE_DEPTH];
    mrt_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/core/mrt_match.sv
// Shared compare unit: masked compare for lookups, exact compare for deletes.
// Depends on mrt_pkg.
module mrt_match (
    input  mrt_pkg::t_cmp_req i_cmp,
    output logic              o_match
);
    logic [31:0] masked_key;
    logic [31:0] masked_dest;

    assign masked_key  = i_cmp.exact ? i_cmp.key  : (i_cmp.key  & i_cmp.mask);
    assign masked_dest = i_cmp.exact ? i_cmp.dest : (i_cmp.dest & i_cmp.mask);
    assign o_match     = (masked_key == masked_dest);
endmodule

FILE: rtl/core/mrt_ctrl.sv
// Sequencer of the masked route table: walks the table one entry per cycle,
// shifts entries up after a delete and holds the result register.
// Depends on mrt_pkg, mrt_req_if and mrt_rsp_if.
module mrt_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    mrt_req_if.sink                     i_req,
    mrt_rsp_if.source                   o_rsp,
    output mrt_pkg::t_mem_wr            o_wr,
    output logic [mrt_pkg::IDX_W-1:0]   o_raddr,
    input  mrt_pkg::t_entry             i_rdata,
    output mrt_pkg::t_cmp_req           o_cmp,
    input  logic                        i_match
);
    mrt_pkg::t_state                r_state, n_state;
    logic [mrt_pkg::CNT_W-1:0]      r_count, n_count;
    logic [mrt_pkg::IDX_W-1:0]      r_ptr, n_ptr;
    logic [mrt_pkg::IDX_W-1:0]      r_hit, n_hit;
    logic [31:0]                    r_key, n_key;
    logic                           r_del, n_del;
    logic                           r_out_valid, n_out_valid;
    mrt_pkg::t_rsp                  r_out, n_out;

    logic                           out_free;
    logic                           accept;
    logic [mrt_pkg::CMP_W-1:0]      ptr_p1;
    logic [mrt_pkg::CMP_W-1:0]      ptr_p2;
    logic [mrt_pkg::CMP_W-1:0]      cnt_ext;
    mrt_pkg::t_rsp                  res;

    assign out_free    = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == mrt_pkg::S_IDLE) && out_free;
    assign accept      = i_req.valid && i_req.ready;

    assign ptr_p1  = mrt_pkg::CMP_W'(r_ptr) + mrt_pkg::CMP_W'(1);
    assign ptr_p2  = mrt_pkg::CMP_W'(r_ptr) + mrt_pkg::CMP_W'(2);
    assign cnt_ext = mrt_pkg::CMP_W'(r_count);

    assign o_cmp.key   = r_key;
    assign o_cmp.dest  = i_rdata.dest;
    assign o_cmp.mask  = i_rdata.mask;
    assign o_cmp.exact = r_del;

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mrt_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        r_hit <= n_hit;
        r_key <= n_key;
        r_del <= n_del;
        r_out <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_hit       = r_hit;
        n_key       = r_key;
        n_del       = r_del;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out       = r_out;

        res        = '0;
        res.status = mrt_pkg::ST_MISS;

        o_wr.we           = 1'b0;
        o_wr.addr         = mrt_pkg::IDX_W'(r_count);
        o_wr.data.dest    = i_req.payload.dest_addr;
        o_wr.data.mask    = i_req.payload.net_mask;
        o_wr.data.gateway = i_req.payload.gateway_addr;
        o_wr.data.port    = i_req.payload.port_id;
        o_wr.data.cost    = i_req.payload.route_cost;
        o_raddr           = '0;

        unique case (r_state)
            mrt_pkg::S_IDLE: begin
                // The first entry is fetched every idle cycle so a scan starts at once.
                o_raddr = '0;
                if (accept) begin
                    unique case (i_req.payload.operation)
                        mrt_pkg::OP_ADD: begin
                            if (r_count == mrt_pkg::CNT_W'(mrt_pkg::TABLE_DEPTH)) begin
                                res.status = mrt_pkg::ST_FULL;
                            end else begin
                                o_wr.we       = 1'b1;
                                n_count       = r_count + mrt_pkg::CNT_W'(1);
                                res.status    = mrt_pkg::ST_OK;
                                res.hit_index = 8'(r_count);
                            end
                            n_out_valid = 1'b1;
                            n_out       = res;
                        end
                        mrt_pkg::OP_LOOKUP, mrt_pkg::OP_DELETE: begin
                            if (r_count == '0) begin
                                n_out_valid = 1'b1;
                                n_out       = res;
                            end else begin
                                n_ptr   = '0;
                                n_del   = (i_req.payload.operation == mrt_pkg::OP_DELETE);
                                n_key   = (i_req.payload.operation == mrt_pkg::OP_DELETE)
                                        ? i_req.payload.dest_addr
                                        : mrt_pkg::swap_bytes(i_req.payload.dest_addr);
                                n_state = mrt_pkg::S_CHECK;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_out       = res;
                        end
                    endcase
                end
            end

            mrt_pkg::S_CHECK: begin
                // Read data belongs to r_ptr; the next entry is fetched alongside.
                o_raddr = mrt_pkg::IDX_W'(ptr_p1);
                if (i_match) begin
                    res.status    = mrt_pkg::ST_OK;
                    res.hit_index = 8'(r_ptr);
                    if (!r_del) begin
                        res.hit_gateway = i_rdata.gateway;
                        res.hit_mask    = i_rdata.mask;
                        res.hit_port    = i_rdata.port;
                        res.hit_cost    = i_rdata.cost;
                        n_out_valid     = 1'b1;
                        n_out           = res;
                        n_state         = mrt_pkg::S_IDLE;
                    end else if (ptr_p1 >= cnt_ext) begin
                        n_count     = r_count - mrt_pkg::CNT_W'(1);
                        n_out_valid = 1'b1;
                        n_out       = res;
                        n_state     = mrt_pkg::S_IDLE;
                    end else begin
                        n_hit   = r_ptr;
                        n_state = mrt_pkg::S_SHIFT;
                    end
                end else if (ptr_p1 >= cnt_ext) begin
                    n_out_valid = 1'b1;
                    n_out       = res;
                    n_state     = mrt_pkg::S_IDLE;
                end else begin
                    n_ptr = mrt_pkg::IDX_W'(ptr_p1);
                end
            end

            mrt_pkg::S_SHIFT: begin
                // Read data holds the entry after r_ptr; it moves up one place.
                o_raddr   = mrt_pkg::IDX_W'(ptr_p2);
                o_wr.we   = 1'b1;
                o_wr.addr = r_ptr;
                o_wr.data = i_rdata;
                if (ptr_p2 >= cnt_ext) begin
                    res.status    = mrt_pkg::ST_OK;
                    res.hit_index = 8'(r_hit);
                    n_count       = r_count - mrt_pkg::CNT_W'(1);
                    n_out_valid   = 1'b1;
                    n_out         = res;
                    n_state       = mrt_pkg::S_IDLE;
                end else begin
                    n_ptr = mrt_pkg::IDX_W'(ptr_p1);
                end
            end

            default: begin
                n_state = mrt_pkg::S_IDLE;
            end
        endcase
    end
endmodule

FILE: rtl/core/mrt_checker.sv
// Port-level checks for the masked route table, bound to the top level.
// Depends on mrt_pkg, the channel interfaces and masked_route_table_assert.svh.
`include "masked_route_table_assert.svh"

module mrt_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    mrt_req_if.sink     i_req,
    mrt_rsp_if.source   o_rsp
);
    logic           rsp_valid;
    logic           rsp_stall;
    logic           rsp_failed;
    logic           rsp_blank;
    logic           req_open;
    mrt_pkg::t_rsp  rsp_data;

    assign rsp_valid  = o_rsp.valid;
    assign rsp_data   = o_rsp.payload;
    assign rsp_stall  = o_rsp.valid && !o_rsp.ready;
    assign rsp_failed = o_rsp.valid && (rsp_data.status != mrt_pkg::ST_OK);
    assign rsp_blank  = (rsp_data.hit_index == 8'd0) && (rsp_data.hit_gateway == 32'd0)
                     && (rsp_data.hit_mask == 32'd0) && (rsp_data.hit_port == 8'd0)
                     && (rsp_data.hit_cost == 16'd0);
    assign req_open   = i_req.ready && o_rsp.valid;

    // No result may be offered in the cycle after reset.
    `MRT_ASSERT_NEXT(a_rst_quiet, i_clk, 1'b1, !i_rst_n, !rsp_valid, "result after reset")

    // A stalled result keeps its payload.
    `MRT_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, rsp_stall, rsp_valid && $stable(rsp_data), "result moved")

    // Anything other than a hit or a successful add or delete carries only zeros.
    `MRT_ASSERT_IMPLIES(a_miss_zero, i_clk, i_rst_n, rsp_failed, rsp_blank, "non-hit result has data")

    // A new item is taken only when the result register can take its result.
    `MRT_ASSERT_IMPLIES(a_no_overrun, i_clk, i_rst_n, req_open, o_rsp.ready, "request taken while stalled")
endmodule

bind masked_route_table mrt_checker u_mrt_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_req   (i_req),
    .o_rsp   (o_rsp)
);
